>>> hdl/adc_scan_oversample_accumulator_assert.svh
// Assertion shorthands, clocked on clk and quiet during reset.
`ifndef ADC_SCAN_OVERSAMPLE_ACCUMULATOR_ASSERT_SVH
`define ADC_SCAN_OVERSAMPLE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication.
`define ASO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ASO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/aso_pkg.sv
package aso_pkg;

	localparam int SampleW  = 10;
	localparam int SumW     = 16;
	localparam int MaskW    = 16;
	localparam int CountW   = 5;
	localparam int PassW    = 7;
	localparam int ScanW    = 4;
	localparam int PosW     = $clog2(MaskW);
	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 16;

	// register indexes on the config port
	localparam logic [CfgIdxW-1:0] RegChannelMask     = 2'd0;
	localparam logic [CfgIdxW-1:0] RegChannelCount    = 2'd1;
	localparam logic [CfgIdxW-1:0] RegOversampleCount = 2'd2;
	localparam logic [CfgIdxW-1:0] RegHoldMask        = 2'd3;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_SELECT = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_ACC,
		S_REPORT,
		S_SELECT
	} fsm_t;

	typedef struct packed {
		logic add;
		logic clear;
	} sums_op_t;

	typedef struct packed {
		logic            busy;
		logic [PosW-1:0] pos;
	} bitsel_stat_t;

endpackage

>>> hdl/aso_sums.sv
module aso_sums #(
	parameter int MAX_CHANNELS = 16,
	localparam int IdxW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [IdxW-1:0]           addr,
	input  aso_pkg::sums_op_t         op,
	input  logic [aso_pkg::SumW-1:0]  addend,
	output logic [aso_pkg::SumW-1:0]  rdata
);
	import aso_pkg::*;

	logic [SumW-1:0] sums_q [MAX_CHANNELS];

	// single adder, shared by every channel; sums wrap at 16 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
		end else if (op.add) begin
			sums_q[addr] <= sums_q[addr] + addend;
		end else if (op.clear) begin
			sums_q[addr] <= '0;
		end
	end

	assign rdata = sums_q[addr];

endmodule

>>> hdl/aso_bitsel.sv
module aso_bitsel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [aso_pkg::MaskW-1:0]    mask,
	input  logic [aso_pkg::ScanW-1:0]    target,
	output aso_pkg::bitsel_stat_t        stat
);
	import aso_pkg::*;

	localparam logic [PosW-1:0] LastPos = PosW'(MaskW - 1);

	logic             busy_q;
	logic             found_q;
	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  res_q;
	logic [ScanW-1:0] seen_q;
	logic [ScanW-1:0] target_q;

	// one mask bit per cycle; result stays 0 when the set bit does not exist
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			found_q  <= 1'b0;
			pos_q    <= '0;
			res_q    <= '0;
			seen_q   <= '0;
			target_q <= '0;
		end else if (start) begin
			busy_q   <= 1'b1;
			found_q  <= 1'b0;
			pos_q    <= '0;
			res_q    <= '0;
			seen_q   <= '0;
			target_q <= target;
		end else if (busy_q) begin
			if (mask[pos_q] && !found_q) begin
				if (seen_q == target_q) begin
					found_q <= 1'b1;
					res_q   <= pos_q;
				end else begin
					seen_q <= seen_q + 1'b1;
				end
			end
			pos_q <= pos_q + 1'b1;
			if (pos_q == LastPos) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.pos  = res_q;

endmodule

>>> hdl/adc_scan_oversample_accumulator.sv
// Scan sequencer for a multiplexed converter with oversampling sums.
// Input channel (in_valid/in_ready, sample): one transfer per service tick.
// Ticks alternate: a start tick yields one start-conversion result; an
// accumulate tick adds the sample to the current logical channel's sum unless
// it is held, steps to the next channel and yields, when a window of
// oversample_count full scans closes, one report per logical channel, then
// an input-select result naming the physical input for the next conversion.
// Output channel (out_valid/out_ready, kind .. last): one result per transfer,
// last marks the final result of a tick.
// In an accumulate tick the bit-serial search of channel_mask for the selected
// input (one mask bit per cycle) runs before the select result, and when a
// window closes the report sweep first visits every sum once.
// in_ready is high only while the sequencer is idle; the last result of a tick
// sits in the output register, so a new tick may be taken before it leaves.
// A stalled receiver halts the sequencer at its next result; nothing is lost.
// Reset: registers to their defaults (all sixteen inputs, count 16, window 16,
// nothing held), sums and pass count to zero, start phase next.
// Configuration writes are registered on cfg_we; write only when idle.
module adc_scan_oversample_accumulator #(
	parameter int MAX_CHANNELS = 16,
	parameter int SAMPLE_BITS  = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [aso_pkg::CfgIdxW-1:0]    cfg_idx,
	input  logic [aso_pkg::CfgDataW-1:0]   cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [aso_pkg::SampleW-1:0]    sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     kind,
	output logic [aso_pkg::ScanW-1:0]      mux_channel,
	output logic [aso_pkg::ScanW-1:0]      report_channel,
	output logic [aso_pkg::SumW-1:0]       report_sum,
	output logic                           last
);
	import aso_pkg::*;

	localparam int IdxW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int UsedBits = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;
	localparam logic [SampleW-1:0] SampleMask = SampleW'((1 << UsedBits) - 1);
	localparam logic [CountW-1:0]  MaxCount   = CountW'(MAX_CHANNELS);
	localparam logic [IdxW-1:0]    LastRep    = IdxW'(MAX_CHANNELS - 1);

	// configuration registers
	logic [MaskW-1:0]  chan_mask_q;
	logic [CountW-1:0] chan_count_q;
	logic [PassW-1:0]  os_count_q;
	logic [MaskW-1:0]  hold_mask_q;

	// sequencer state
	fsm_t              state_q, state_d;
	logic              converting_q;
	logic [ScanW-1:0]  scan_q;
	logic [PassW-1:0]  pass_q;
	logic [IdxW-1:0]   rep_q;
	logic [SampleW-1:0] sample_q;

	// output register
	logic              out_valid_q;
	kind_t             kind_q;
	logic [ScanW-1:0]  mux_q;
	logic [ScanW-1:0]  rch_q;
	logic [SumW-1:0]   sum_q;
	logic              last_q;

	// datapath
	logic [CountW-1:0] eff_count;
	logic [CountW-1:0] idx_inc;
	logic              wrap;
	logic [ScanW-1:0]  scan_new;
	logic [PassW-1:0]  pass_inc;
	logic              window_end;
	logic              rep_live;
	logic              rep_go;
	logic              slot_free;

	logic              emit;
	kind_t             emit_kind;
	logic [ScanW-1:0]  emit_mux;
	logic [ScanW-1:0]  emit_rch;
	logic [SumW-1:0]   emit_sum;
	logic              emit_last;

	sums_op_t          sums_op;
	logic [IdxW-1:0]   sums_addr;
	logic [SumW-1:0]   sums_rdata;
	logic              bs_start;
	logic [ScanW-1:0]  bs_target;
	bitsel_stat_t      bs_stat;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_mask_q  <= '1;
			chan_count_q <= CountW'(16);
			os_count_q   <= PassW'(16);
			hold_mask_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegChannelMask:     chan_mask_q  <= cfg_wdata;
				RegChannelCount:    chan_count_q <= cfg_wdata[CountW-1:0];
				RegOversampleCount: os_count_q   <= cfg_wdata[PassW-1:0];
				RegHoldMask:        hold_mask_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// count of zero scans one channel; above the array depth it saturates
	always_comb begin
		if (chan_count_q == '0) begin
			eff_count = CountW'(1);
		end else if (chan_count_q > MaxCount) begin
			eff_count = MaxCount;
		end else begin
			eff_count = chan_count_q;
		end
	end

	assign idx_inc    = CountW'(scan_q) + 1'b1;
	assign wrap       = (idx_inc >= eff_count);
	assign scan_new   = wrap ? '0 : idx_inc[ScanW-1:0];
	assign pass_inc   = pass_q + 1'b1;
	assign window_end = wrap && (pass_inc >= os_count_q);
	assign rep_live   = (CountW'(rep_q) < eff_count);
	assign slot_free  = !out_valid_q || out_ready;
	// sweep steps freely past the unused channels (clear only), waits on a report
	assign rep_go     = !rep_live || slot_free;
	assign sums_addr  = (state_q == S_REPORT) ? rep_q : scan_q[IdxW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = converting_q ? S_ACC : S_START;
				end
			end
			S_START: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			S_ACC: begin
				state_d = window_end ? S_REPORT : S_SELECT;
			end
			S_REPORT: begin
				if (rep_go && (rep_q == LastRep)) begin
					state_d = S_SELECT;
				end
			end
			S_SELECT: begin
				if (!bs_stat.busy && slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_START;
		emit_mux  = '0;
		emit_rch  = '0;
		emit_sum  = '0;
		emit_last = 1'b0;
		sums_op   = '0;
		bs_start  = 1'b0;
		bs_target = scan_q;
		case (state_q)
			S_START: begin
				emit      = slot_free;
				emit_last = 1'b1;
			end
			S_ACC: begin
				sums_op.add = !hold_mask_q[scan_q];
				bs_start    = !window_end;
				bs_target   = scan_new;
			end
			S_REPORT: begin
				if (rep_go) begin
					sums_op.clear = !hold_mask_q[rep_q];
					emit          = rep_live;
					bs_start      = (rep_q == LastRep);
				end
				emit_kind = KIND_REPORT;
				emit_rch  = ScanW'(rep_q);
				emit_sum  = sums_rdata;
			end
			S_SELECT: begin
				emit      = !bs_stat.busy && slot_free;
				emit_kind = KIND_SELECT;
				emit_mux  = bs_stat.pos;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			converting_q <= 1'b0;
			scan_q       <= '0;
			pass_q       <= '0;
			rep_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_START) && slot_free) begin
				converting_q <= 1'b1;
			end else if ((state_q == S_SELECT) && emit) begin
				converting_q <= 1'b0;
			end
			if (state_q == S_ACC) begin
				scan_q <= scan_new;
				rep_q  <= '0;
				if (wrap) begin
					pass_q <= window_end ? '0 : pass_inc;
				end
			end
			if ((state_q == S_REPORT) && rep_go) begin
				rep_q <= rep_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_valid) begin
			sample_q <= sample & SampleMask;
		end
		if (emit) begin
			kind_q <= emit_kind;
			mux_q  <= emit_mux;
			rch_q  <= emit_rch;
			sum_q  <= emit_sum;
			last_q <= emit_last;
		end
	end

	aso_sums #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_sums (
		.clk    (clk),
		.arst_n (arst_n),
		.addr   (sums_addr),
		.op     (sums_op),
		.addend (SumW'(sample_q)),
		.rdata  (sums_rdata)
	);

	aso_bitsel u_bitsel (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bs_start),
		.mask   (chan_mask_q),
		.target (bs_target),
		.stat   (bs_stat)
	);

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign mux_channel    = mux_q;
	assign report_channel = rch_q;
	assign report_sum     = sum_q;
	assign last           = last_q;

	`include "adc_scan_oversample_accumulator_assert.svh"

	// the input search only runs once the sums are settled
	`ASO_ASSERT_IMP(a_search_idle, (state_q == S_IDLE) || (state_q == S_REPORT), !bs_stat.busy, "input search busy outside select phase")
	// a waiting result is never overwritten
	`ASO_ASSERT_IMP(a_no_overwrite, out_valid_q && !out_ready, !emit, "result register overwritten while stalled")
	// input select closes the tick and returns to the start phase
	`ASO_ASSERT_NXT(a_select_ends, emit && (emit_kind == KIND_SELECT), !converting_q && (state_q == S_IDLE), "select result did not end the tick")

endmodule
